// ----- sv/rbmf_pkg.sv -----
`default_nettype none
package rbmf_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int HEIGHT_W      = 13;
  localparam int RES_DEPTH     = 8;
  localparam int ROWS_KEPT     = 4;
  // floor(s * 7282 / 2^16) == floor(s / 9) for s < 32768
  localparam logic [12:0] RECIP_9 = 13'd7282;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_RED    = 3'd2,
    REG_GREEN  = 3'd3,
    REG_BLUE   = 3'd4
  } cfg_reg_t;

  typedef logic [23:0] pix_t;

  // one new column of the window: top is two rows up, bot is the current row
  typedef struct packed {
    logic valid;
    pix_t top;
    pix_t mid;
    pix_t bot;
    logic col_zero;
    logic col_one;
    logic has_out;
    logic frame_end;
  } column_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } result_t;

  typedef struct packed {
    logic [1:0] busy;
  } back_stat_t;

endpackage
`default_nettype wire

// ----- sv/rbmf_front.sv -----
`default_nettype none
module rbmf_front #(
  parameter int MAX_WIDTH = rbmf_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic                          opcode,
  input  wire logic [7:0]                    in_red,
  input  wire logic [7:0]                    in_green,
  input  wire logic [7:0]                    in_blue,
  input  wire logic [$clog2(MAX_WIDTH):0]    eff_w,
  input  wire logic [rbmf_pkg::HEIGHT_W-1:0] eff_h,
  input  wire rbmf_pkg::pix_t                border,
  output rbmf_pkg::column_t                  column
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int HW    = rbmf_pkg::HEIGHT_W;
  localparam int CNT_W = $clog2(rbmf_pkg::MAX_HEIGHT * MAX_WIDTH + MAX_WIDTH + 1);

  logic [CW-1:0]    col;
  logic [HW-1:0]    row;
  logic [CNT_W-1:0] cur;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] lag;

  logic [24:0] store [rbmf_pkg::ROWS_KEPT][MAX_WIDTH];
  logic [24:0] rd    [rbmf_pkg::ROWS_KEPT];
  logic [24:0] wdata;

  logic        v1;
  logic [24:0] pix1;
  logic [1:0]  rlo1;
  logic        vr0_1, vr1_1, vr2_1;
  logic        colz1, colone1, hasout1, fend1;

  logic [CW:0]   col_inc;
  logic [HW:0]   row_x, h_x;
  logic          vr0, vr1, vr2;
  logic [24:0]   top_raw, mid_raw;

  assign wdata   = {opcode, in_blue, in_green, in_red};
  assign col_inc = {1'b0, col} + 1'b1;
  assign row_x   = {1'b0, row};
  assign h_x     = {1'b0, eff_h};
  assign vr0     = row_x < h_x;
  assign vr1     = (row_x != '0) && (row_x <= h_x);
  assign vr2     = (row_x >= (HW+1)'(2)) && (row_x <= h_x + 1'b1);

  // frame end position (h*w + w) and first output position (w + 1)
  always_ff @(posedge clk) begin
    lim <= CNT_W'(eff_h) * CNT_W'(eff_w) + CNT_W'(eff_w);
    lag <= CNT_W'(eff_w) + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      cur <= '0;
    end else if (accept) begin
      if (cur >= lim) begin
        col <= '0;
        row <= '0;
        cur <= '0;
      end else begin
        cur <= cur + 1'b1;
        if (col_inc >= eff_w) begin
          col <= '0;
          row <= row + 1'b1;
        end else begin
          col <= col_inc[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int b = 0; b < rbmf_pkg::ROWS_KEPT; b++) begin
        if (row[1:0] == 2'(b)) begin
          store[b][col] <= wdata;
        end
        rd[b] <= store[b][col];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    if (accept) begin
      pix1    <= wdata;
      rlo1    <= row[1:0];
      vr0_1   <= vr0;
      vr1_1   <= vr1;
      vr2_1   <= vr2;
      colz1   <= (col == '0);
      colone1 <= (col == CW'(1));
      hasout1 <= (cur >= lag) && (cur <= lim);
      fend1   <= (cur == lim);
    end
  end

  assign top_raw = rd[rlo1 - 2'd2];
  assign mid_raw = rd[rlo1 - 2'd1];

  always_comb begin
    column.valid     = v1;
    column.top       = (vr2_1 && !top_raw[24]) ? top_raw[23:0] : border;
    column.mid       = (vr1_1 && !mid_raw[24]) ? mid_raw[23:0] : border;
    column.bot       = (vr0_1 && !pix1[24])    ? pix1[23:0]    : border;
    column.col_zero  = colz1;
    column.col_one   = colone1;
    column.has_out   = hasout1;
    column.frame_end = fend1;
  end

endmodule
`default_nettype wire

// ----- sv/rbmf_back.sv -----
`default_nettype none
module rbmf_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rbmf_pkg::column_t  column,
  input  wire rbmf_pkg::pix_t     border,
  input  wire logic               width_one,
  output logic                    res_push,
  output rbmf_pkg::result_t       res_data,
  output rbmf_pkg::back_stat_t    stat
);

  // s0 newest column, s2 oldest; each holds top, mid, bot
  logic [2:0][23:0] s0, s1, s2;
  logic             v2, colz2, colone2, hasout2, fend2;
  logic             v3, hasout3, fend3;
  logic [2:0][11:0] sum3;

  logic [2:0][23:0] left, right;
  logic [2:0][11:0] sum;
  logic [2:0][24:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v2 <= column.valid;
      v3 <= v2;
    end
    if (column.valid) begin
      s0      <= {column.top, column.mid, column.bot};
      s1      <= s0;
      s2      <= s1;
      colz2   <= column.col_zero;
      colone2 <= column.col_one;
      hasout2 <= column.has_out;
      fend2   <= column.frame_end;
    end
    if (v2) begin
      sum3    <= sum;
      hasout3 <= hasout2;
      fend3   <= fend2;
    end
  end

  always_comb begin
    if (colz2) begin
      left  = width_one ? {3{border}} : s2;
      right = {3{border}};
    end else begin
      left  = colone2 ? {3{border}} : s2;
      right = s0;
    end
    for (int c = 0; c < 3; c++) begin
      sum[c] = '0;
      for (int r = 0; r < 3; r++) begin
        sum[c] = sum[c] + 12'(left[r][8*c +: 8]) + 12'(s1[r][8*c +: 8])
                        + 12'(right[r][8*c +: 8]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = 25'(sum3[c]) * 25'(rbmf_pkg::RECIP_9);
    end
  end

  assign res_push           = v3 && hasout3;
  assign res_data.red       = prod[0][23:16];
  assign res_data.green     = prod[1][23:16];
  assign res_data.blue      = prod[2][23:16];
  assign res_data.frame_end = fend3;
  assign stat.busy          = 2'(v2) + 2'(v3);

endmodule
`default_nettype wire

// ----- sv/rbmf_fifo.sv -----
`default_nettype none
module rbmf_fifo #(
  parameter int DEPTH = rbmf_pkg::RES_DEPTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  input  wire rbmf_pkg::result_t       wdata,
  input  wire logic                    pop,
  output rbmf_pkg::result_t            rdata,
  output logic                         empty,
  output logic [$clog2(DEPTH):0]       count
);

  localparam int AW = $clog2(DEPTH);

  rbmf_pkg::result_t mem [DEPTH];
  logic [AW-1:0]     wptr, rptr;
  logic              do_pop;

  assign empty  = (count == '0);
  assign do_pop = pop && !empty;
  assign rdata  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ----- sv/rgb_box_mean_filter.sv -----
// A pixel's result passes the front, shift and sum registers and the result queue
// after the item completing its window (a row plus a pixel later in the stream).
// Throughput: one item per cycle; four line-store banks give three rows per cycle.
// Input stalls only while the 8-entry result queue plus in-flight items is full.
// Reset (synchronous, rst high): counters and queue cleared, width 640, height 480,
// border black; line store contents are not cleared.
`default_nettype none
module rgb_box_mean_filter #(
  parameter int MAX_WIDTH = rbmf_pkg::DEF_MAX_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        opcode,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic             frame_end,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int HW    = rbmf_pkg::HEIGHT_W;
  localparam int QW    = $clog2(rbmf_pkg::RES_DEPTH);
  localparam int RST_W = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;

  logic [CW:0]       eff_w;
  logic [HW-1:0]     eff_h;
  rbmf_pkg::pix_t    border;

  rbmf_pkg::column_t    column;
  rbmf_pkg::back_stat_t stat;
  rbmf_pkg::result_t    res_in, res_out;
  logic                 res_push;
  logic [QW:0]          q_count;
  logic                 accept;
  logic [QW+1:0]        inflight;

  assign cfg_ready = 1'b1;
  assign inflight  = (QW+2)'(q_count) + (QW+2)'(column.valid) + (QW+2)'(stat.busy);
  assign full      = inflight >= (QW+2)'(rbmf_pkg::RES_DEPTH);
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w  <= (CW+1)'(RST_W);
      eff_h  <= HW'(480);
      border <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rbmf_pkg::REG_WIDTH: begin
          if (cfg_data[10:0] == '0) begin
            eff_w <= (CW+1)'(1);
          end else if (32'(cfg_data[10:0]) > MAX_WIDTH) begin
            eff_w <= (CW+1)'(MAX_WIDTH);
          end else begin
            eff_w <= (CW+1)'(cfg_data[10:0]);
          end
        end
        rbmf_pkg::REG_HEIGHT: begin
          if (cfg_data == '0) begin
            eff_h <= HW'(1);
          end else if (32'(cfg_data) > rbmf_pkg::MAX_HEIGHT) begin
            eff_h <= HW'(rbmf_pkg::MAX_HEIGHT);
          end else begin
            eff_h <= cfg_data;
          end
        end
        rbmf_pkg::REG_RED:   border[7:0]   <= cfg_data[7:0];
        rbmf_pkg::REG_GREEN: border[15:8]  <= cfg_data[7:0];
        rbmf_pkg::REG_BLUE:  border[23:16] <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  rbmf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .opcode   (opcode),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .eff_w    (eff_w),
    .eff_h    (eff_h),
    .border   (border),
    .column   (column)
  );

  rbmf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .column    (column),
    .border    (border),
    .width_one (eff_w == (CW+1)'(1)),
    .res_push  (res_push),
    .res_data  (res_in),
    .stat      (stat)
  );

  rbmf_fifo #(.DEPTH(rbmf_pkg::RES_DEPTH)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty),
    .count (q_count)
  );

  assign out_red   = res_out.red;
  assign out_green = res_out.green;
  assign out_blue  = res_out.blue;
  assign frame_end = res_out.frame_end;

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`default_nettype none
module testbench;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } mean_pix_t;

  // Window-mean predictor plus the queue of pending means.
  class mean_scoreboard;
    int unsigned width_reg, height_reg;
    logic [7:0]  bord_r, bord_g, bord_b;
    logic [24:0] line_mem [rbmf_pkg::ROWS_KEPT * rbmf_pkg::DEF_MAX_WIDTH];
    int unsigned col_pos, row_pos;
    mean_pix_t   pending [$];
    int          errors;
    int          n_checked;
    int          n_frames;

    function new();
      width_reg  = 640;
      height_reg = 480;
      bord_r = 8'd0; bord_g = 8'd0; bord_b = 8'd0;
      foreach (line_mem[i]) line_mem[i] = '0;
      col_pos = 0; row_pos = 0;
      errors = 0; n_checked = 0; n_frames = 0;
    endfunction

    function void write_reg(rbmf_pkg::cfg_reg_t idx, logic [12:0] val);
      case (idx)
        rbmf_pkg::REG_WIDTH:  width_reg  = val[10:0];
        rbmf_pkg::REG_HEIGHT: height_reg = val;
        rbmf_pkg::REG_RED:    bord_r = val[7:0];
        rbmf_pkg::REG_GREEN:  bord_g = val[7:0];
        rbmf_pkg::REG_BLUE:   bord_b = val[7:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned w, h, col, row, cur, lag, o, last, sr, sg, sb;
      int ci, cj, k, l;
      logic [23:0] px;
      logic [24:0] v;
      mean_pix_t   m;
      w = (width_reg == 0) ? 1 :
          (width_reg > rbmf_pkg::DEF_MAX_WIDTH) ? rbmf_pkg::DEF_MAX_WIDTH : width_reg;
      h = (height_reg == 0) ? 1 :
          (height_reg > rbmf_pkg::MAX_HEIGHT) ? rbmf_pkg::MAX_HEIGHT : height_reg;
      col = col_pos;
      row = row_pos;
      if (col >= w) begin
        col = 0;
        row++;
      end
      line_mem[(row % rbmf_pkg::ROWS_KEPT) * rbmf_pkg::DEF_MAX_WIDTH + col] =
        op ? 25'h1000000 : {1'b0, b, g, r};
      cur = row * w + col;
      col++;
      if (col >= w) begin
        col = 0;
        row++;
      end
      col_pos = col;
      row_pos = row;
      lag = w + 1;
      if (cur < lag) return;
      o = cur - lag;
      last = h * w - 1;
      if (o > last) begin
        col_pos = 0;
        row_pos = 0;
        return;
      end
      ci = o / w;
      cj = o % w;
      sr = 0; sg = 0; sb = 0;
      for (int a = -1; a <= 1; a++) begin
        for (int c = -1; c <= 1; c++) begin
          k = ci + a;
          l = cj + c;
          px = {bord_b, bord_g, bord_r};
          if (k >= 0 && l >= 0 && k < int'(h) && l < int'(w)) begin
            v = line_mem[(k % rbmf_pkg::ROWS_KEPT) * rbmf_pkg::DEF_MAX_WIDTH + l];
            if (!v[24]) px = v[23:0];
          end
          sr += px[7:0];
          sg += px[15:8];
          sb += px[23:16];
        end
      end
      m.red = 8'(sr / 9);
      m.green = 8'(sg / 9);
      m.blue = 8'(sb / 9);
      m.frame_end = (o == last);
      pending.push_back(m);
      if (o == last) begin
        col_pos = 0;
        row_pos = 0;
      end
    endfunction

    function void check_result(mean_pix_t got);
      mean_pix_t exp_m;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_m = pending.pop_front();
      n_checked++;
      if (got.frame_end) n_frames++;
      if (got.red !== exp_m.red)
        $display("%0t: red exp %h got %h", $time, exp_m.red, got.red);
      if (got.green !== exp_m.green)
        $display("%0t: green exp %h got %h", $time, exp_m.green, got.green);
      if (got.blue !== exp_m.blue)
        $display("%0t: blue exp %h got %h", $time, exp_m.blue, got.blue);
      if (got.frame_end !== exp_m.frame_end)
        $display("%0t: frame_end exp %b got %b", $time, exp_m.frame_end, got.frame_end);
      if (got !== exp_m) errors++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        opcode = 1'b0;
  logic [7:0]  in_red = '0, in_green = '0, in_blue = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_red, out_green, out_blue;
  logic        frame_end;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  mean_scoreboard sb = new();
  bit hold_req = 1'b0;
  int idle_cycles = 0;
  int n_items = 0;

  always #5 clk = ~clk;

  rgb_box_mean_filter dut (
    .clk, .rst, .push, .full, .opcode, .in_red, .in_green, .in_blue,
    .empty, .pop, .out_red, .out_green, .out_blue, .frame_end,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // watchdog: ends the run after too long without any transfer
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // receiver
  initial begin
    int gap;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      sb.check_result({out_red, out_green, out_blue, frame_end});
    end
  end

  task automatic send_item(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    opcode <= op;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    do @(posedge clk); while (full);
    sb.note_input(op, r, g, b);
    n_items++;
  endtask

  // pause until every pending mean has been checked, plus pipeline latency
  task automatic wait_idle();
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_cfg(rbmf_pkg::cfg_reg_t idx, logic [12:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic set_frame(logic [12:0] w, logic [12:0] h,
                           logic [7:0] r, logic [7:0] g, logic [7:0] b);
    wait_idle();
    write_cfg(rbmf_pkg::REG_WIDTH, w);
    write_cfg(rbmf_pkg::REG_HEIGHT, h);
    write_cfg(rbmf_pkg::REG_RED, {5'd0, r});
    write_cfg(rbmf_pkg::REG_GREEN, {5'd0, g});
    write_cfg(rbmf_pkg::REG_BLUE, {5'd0, b});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one whole frame then the drain items; drain items are random
  // (pixels past the last row drain just like flush items)
  task automatic run_frame(int w, int h, int flush_pct);
    for (int i = 0; i < w * h; i++)
      send_item(($urandom_range(0, 99) < flush_pct), pick_byte(), pick_byte(), pick_byte());
    for (int i = 0; i < w + 1; i++)
      send_item(1'($urandom_range(0, 1)), pick_byte(), pick_byte(), pick_byte());
  endtask

  initial begin
    int w, h;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: 3x2 frame with extremes, a flush inside the image, odd border
    set_frame(13'd3, 13'd2, 8'hff, 8'h00, 8'h80);
    send_item(1'b0, 8'hff, 8'hff, 8'hff);
    send_item(1'b0, 8'h00, 8'h00, 8'h00);
    send_item(1'b1, 8'hff, 8'hff, 8'hff);
    send_item(1'b0, 8'hff, 8'h00, 8'hff);
    send_item(1'b0, 8'h00, 8'hff, 8'h00);
    send_item(1'b0, 8'h80, 8'h7f, 8'h01);
    repeat (4) send_item(1'b1, 8'h00, 8'h00, 8'h00);
    // zero width and height clamp to one
    set_frame(13'd0, 13'd0, 8'hff, 8'hff, 8'hff);
    send_item(1'b0, 8'h12, 8'h34, 8'h56);
    send_item(1'b0, 8'hff, 8'hff, 8'hff);
    send_item(1'b1, 8'h00, 8'h00, 8'h00);

    // random small frames
    for (int f = 0; n_items < 600; f++) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      if (f == 3) begin
        w = 6;
        h = 4;
      end
      set_frame(13'(w), 13'(h), pick_byte(), pick_byte(), pick_byte());
      if (f == 3) begin
        // receiver holds off while the sender keeps offering
        hold_req = 1'b1;
        run_frame(w, h, 15);
        run_frame(w, h, 15);
        run_frame(w, h, 15);
      end else begin
        run_frame(w, h, 12);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("covered %0d items, %0d means checked over %0d frames",
             n_items, sb.n_checked, sb.n_frames);
    $display("border, zero sizes clamped to one, in-image flushes and drain pixels exercised");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
sv/rbmf_pkg.sv
sv/rbmf_front.sv
sv/rbmf_back.sv
sv/rbmf_fifo.sv
sv/rgb_box_mean_filter.sv
sim/testbench.sv
